/* rtl/crmx_pkg.sv */
// shared types and constants for the counter-based multiply/xor random word block
// no dependencies; imported by every rtl module of the block

package crmx_pkg;

   localparam int LANES      = 8;
   localparam int ROUNDS     = 10;
   localparam int WORD_W     = 32;
   localparam int BOUND_W    = 31;
   localparam int SEED_W     = 64;
   localparam int PROD_W     = 2 * WORD_W;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 4;

   localparam int LANE_W     = $clog2(LANES);
   localparam int IDX_W      = $clog2(LANES + 1);
   // slots per round: small lane counts need idle slots so a write lands before its next read
   localparam int SLOTS      = (LANES < 4) ? 4 : LANES;
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int RND_W      = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
   localparam int DIV_STEPS  = WORD_W;
   localparam int BIT_W      = $clog2(DIV_STEPS);

   localparam logic [WORD_W-1:0] MULT_RESET = 32'd3528531795;

   // register index codes (byte address bit above the 8-byte stride)
   localparam logic REG_SEED = 1'b0;
   localparam logic REG_MULT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MIX,
      ST_DRAIN_A,
      ST_DRAIN_B,
      ST_FETCH,
      ST_INIT,
      ST_DIV,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic              accept;
      logic              fetch;
      logic              load_en;
      logic [LANE_W-1:0] load_lane;
      logic              issue_en;
      logic [LANE_W-1:0] issue_lane;
      logic              issue_odd;
      logic              batch_done;
      logic              div_init;
      logic              div_step;
      logic              out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic buf_empty;
      logic bound_zero;
      logic out_free;
   } dp_status_type;

endpackage

/* rtl/crmx_csr.sv */
// configuration registers: seed and round multiplier behind an apb-style port
// depends on crmx_pkg

module crmx_csr import crmx_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [SEED_W-1:0]     seed,
   output logic [WORD_W-1:0]     mult_const
);

   logic [SEED_W-1:0] seed_ff;
   logic [WORD_W-1:0] mult_ff;
   logic              wr_en;
   logic              reg_idx;

   assign wr_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx = csr_paddr[CSR_ADDR_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
         mult_ff <= MULT_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            REG_SEED: seed_ff <= csr_pwdata[SEED_W-1:0];
            REG_MULT: mult_ff <= csr_pwdata[WORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SEED: csr_prdata = CSR_DATA_W'(seed_ff);
         REG_MULT: csr_prdata = CSR_DATA_W'(mult_ff);
         default:  csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign seed       = seed_ff;
   assign mult_const = mult_ff;

endmodule

/* rtl/crmx_dp.sv */
// datapath: lane word store, shared multiplier pipe, remainder unit, output register
// depends on crmx_pkg; driven by crmx_ctrl through ctrl_cmd_type

module crmx_dp import crmx_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       status,
   input  logic [BOUND_W-1:0]  req_bound,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [WORD_W-1:0]   rsp_value,
   input  logic [SEED_W-1:0]   seed,
   input  logic [WORD_W-1:0]   mult_const
);

   // lane store doubles as the word buffer once a batch is done
   logic [WORD_W-1:0] lane_mem [LANES];
   logic [WORD_W-1:0] rd_ff;

   logic              issue1_ff, issue2_ff;
   logic [LANE_W-1:0] lane1_ff, lane2_ff;
   logic              odd1_ff, odd2_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;

   logic [WORD_W-1:0]  base_ff;
   logic [IDX_W-1:0]   read_idx_ff;
   logic [BOUND_W-1:0] bound_ff;
   logic [WORD_W-1:0]  word_ff;
   logic [BOUND_W-1:0] rem_ff, rem_in;
   logic               out_valid_ff;
   logic [WORD_W-1:0]  out_value_ff, out_value_in;

   logic              wr_en;
   logic [LANE_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [LANE_W-1:0] rd_addr;
   logic [WORD_W-1:0] mixed;
   logic [WORD_W-1:0] key_word;
   logic [WORD_W:0]   trial;
   logic [WORD_W:0]   bound_ext;

   function automatic logic [LANE_W-1:0] partner_lane(input logic [LANE_W-1:0] l);
      logic [LANE_W-1:0] p;
      p = l ^ LANE_W'(1);
      if ({1'b0, p} < (LANE_W + 1)'(LANES)) begin
         return p;
      end
      return l;
   endfunction

   // round key: even parity of lane xor round takes the low seed half
   assign key_word = (lane2_ff[0] ^ odd2_ff) ? seed[SEED_W-1:WORD_W] : seed[WORD_W-1:0];
   assign mixed    = prod_ff[WORD_W-1:0] ^ prod_ff[PROD_W-1:WORD_W] ^ key_word;

   always_comb begin
      if (cmd.load_en) begin
         wr_en   = 1'b1;
         wr_addr = cmd.load_lane;
         wr_data = base_ff + WORD_W'(cmd.load_lane);
      end else begin
         wr_en   = issue2_ff;
         wr_addr = partner_lane(lane2_ff);
         wr_data = mixed;
      end
   end

   assign rd_addr = cmd.issue_en ? cmd.issue_lane : read_idx_ff[LANE_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lane_mem[wr_addr] <= wr_data;
      end
      rd_ff <= lane_mem[rd_addr];
   end

   // multiply stage, one lane a cycle
   assign prod_in = PROD_W'(rd_ff) * PROD_W'(mult_const);

   always_ff @(posedge clock) begin
      if (reset) begin
         issue1_ff <= 1'b0;
         issue2_ff <= 1'b0;
      end else begin
         issue1_ff <= cmd.issue_en;
         issue2_ff <= issue1_ff;
      end
      lane1_ff <= cmd.issue_lane;
      odd1_ff  <= cmd.issue_odd;
      lane2_ff <= lane1_ff;
      odd2_ff  <= odd1_ff;
      prod_ff  <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= '0;
         read_idx_ff <= IDX_W'(LANES);
      end else if (cmd.batch_done) begin
         base_ff     <= base_ff + WORD_W'(LANES);
         read_idx_ff <= '0;
      end else if (cmd.fetch) begin
         read_idx_ff <= read_idx_ff + IDX_W'(1);
      end
   end

   // restoring remainder, one dividend bit a cycle
   assign bound_ext = {2'b00, bound_ff};
   assign trial     = {1'b0, rem_ff, word_ff[WORD_W-1]};

   always_comb begin
      if (trial >= bound_ext) begin
         rem_in = BOUND_W'(trial - bound_ext);
      end else begin
         rem_in = trial[BOUND_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         bound_ff <= req_bound;
      end
      if (cmd.div_init) begin
         word_ff <= rd_ff;
         rem_ff  <= '0;
      end else if (cmd.div_step) begin
         word_ff <= {word_ff[WORD_W-2:0], 1'b0};
         rem_ff  <= rem_in;
      end
   end

   assign out_value_in = status.bound_zero ? word_ff : WORD_W'(rem_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         out_value_ff <= out_value_in;
      end
   end

   assign status.buf_empty  = (read_idx_ff == IDX_W'(LANES));
   assign status.bound_zero = (bound_ff == '0);
   assign status.out_free   = !out_valid_ff || !rsp_stall;

   assign rsp_valid = out_valid_ff;
   assign rsp_value = out_value_ff;

endmodule

/* rtl/crmx_ctrl.sv */
// controller: sequences batch refill, word fetch, remainder and output hand-off
// depends on crmx_pkg; commands crmx_dp through ctrl_cmd_type

module crmx_ctrl import crmx_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] lane_cnt_ff, lane_cnt_in;
   logic [RND_W-1:0]  round_cnt_ff, round_cnt_in;
   logic [BIT_W-1:0]  bit_cnt_ff, bit_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lane_cnt_ff  <= '0;
         round_cnt_ff <= '0;
         bit_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         lane_cnt_ff  <= lane_cnt_in;
         round_cnt_ff <= round_cnt_in;
         bit_cnt_ff   <= bit_cnt_in;
      end
   end

   // next state and counters
   always_comb begin
      state_in     = state_ff;
      lane_cnt_in  = lane_cnt_ff;
      round_cnt_in = round_cnt_ff;
      bit_cnt_in   = bit_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               lane_cnt_in  = '0;
               round_cnt_in = '0;
               state_in     = status.buf_empty ? ST_LOAD : ST_INIT;
            end
         end
         ST_LOAD: begin
            if (lane_cnt_ff == SLOT_W'(LANES - 1)) begin
               lane_cnt_in = '0;
               state_in    = ST_MIX;
            end else begin
               lane_cnt_in = lane_cnt_ff + SLOT_W'(1);
            end
         end
         ST_MIX: begin
            if (lane_cnt_ff == SLOT_W'(SLOTS - 1)) begin
               lane_cnt_in = '0;
               if (round_cnt_ff == RND_W'(ROUNDS - 1)) begin
                  state_in = ST_DRAIN_A;
               end else begin
                  round_cnt_in = round_cnt_ff + RND_W'(1);
               end
            end else begin
               lane_cnt_in = lane_cnt_ff + SLOT_W'(1);
            end
         end
         ST_DRAIN_A: state_in = ST_DRAIN_B;
         ST_DRAIN_B: state_in = ST_FETCH;
         ST_FETCH:   state_in = ST_INIT;
         ST_INIT: begin
            bit_cnt_in = BIT_W'(DIV_STEPS - 1);
            state_in   = status.bound_zero ? ST_OUTPUT : ST_DIV;
         end
         ST_DIV: begin
            if (bit_cnt_ff == '0) begin
               state_in = ST_OUTPUT;
            end else begin
               bit_cnt_in = bit_cnt_ff - BIT_W'(1);
            end
         end
         ST_OUTPUT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd            = '0;
      cmd.load_lane  = lane_cnt_ff[LANE_W-1:0];
      cmd.issue_lane = lane_cnt_ff[LANE_W-1:0];
      cmd.issue_odd  = round_cnt_ff[0];
      req_stall      = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            cmd.fetch  = req_valid && !status.buf_empty;
         end
         ST_LOAD:    cmd.load_en    = 1'b1;
         ST_MIX:     cmd.issue_en   = ({1'b0, lane_cnt_ff} < (SLOT_W + 1)'(LANES));
         ST_DRAIN_A: ;
         ST_DRAIN_B: cmd.batch_done = 1'b1;
         ST_FETCH:   cmd.fetch      = 1'b1;
         ST_INIT:    cmd.div_init   = 1'b1;
         ST_DIV:     cmd.div_step   = 1'b1;
         ST_OUTPUT:  cmd.out_load   = status.out_free;
         default: ;
      endcase
   end

endmodule

/* rtl/counter_rng_multiply_xor.sv */
// a request runs init, the bit-serial remainder and output; bound 0 skips the remainder
// a request that finds the buffer empty first waits for the batch refill
// one request at a time; the next is taken after the result enters the output register
// refill: 8 lane loads, 80 slots of the one shared 32x32 multiplier, then drain and fetch
// reset: control, counter base and registers return to reset values, buffer marked empty
// top level of the counter-based multiply/xor random word block; uses crmx_pkg, crmx_csr,
// crmx_ctrl and crmx_dp

module counter_rng_multiply_xor import crmx_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [BOUND_W-1:0]    req_bound,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [WORD_W-1:0]     rsp_value,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // config values, taken by the datapath at each refill
   logic [SEED_W-1:0] seed;
   logic [WORD_W-1:0] mult_const;

   // command and status between controller and datapath
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // seed at byte 0, multiplier at byte 8
   crmx_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .seed        (seed),
      .mult_const  (mult_const)
   );

   // one request in flight; a finished word waits in the output register
   // while the next request is taken
   crmx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // lane store, multiply/xor pipe with lane swap on write-back, remainder unit
   crmx_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_bound  (req_bound),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_value  (rsp_value),
      .seed       (seed),
      .mult_const (mult_const)
   );

endmodule

/* rtl/crmx_chk.sv */
// port-level checks for the random word block, bound to the top level
// depends on crmx_pkg and counter_rng_multiply_xor

module crmx_chk import crmx_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [WORD_W-1:0]     rsp_value,
   input logic                  csr_psel,
   input logic                  csr_penable,
   input logic                  csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [CSR_DATA_W-1:0] csr_pwdata,
   input logic [CSR_DATA_W-1:0] csr_prdata,
   input logic                  csr_pready
);

   logic req_xfer;
   logic mult_wr;

   assign req_xfer = req_valid && !req_stall;
   assign mult_wr  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                     csr_paddr[CSR_ADDR_W-1];

   // a waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value))
      else $error("result changed while stalled");

   // one request at a time: busy right after a transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> req_stall)
      else $error("request taken while previous one in progress");

   // a new result only comes out of a busy cycle
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without work in progress");

   // multiplier write reads back
   a_mult_readback: assert property (@(posedge clock) disable iff (reset)
      mult_wr ##1 csr_paddr[CSR_ADDR_W-1] |->
         csr_prdata == CSR_DATA_W'($past(csr_pwdata[WORD_W-1:0])))
      else $error("multiplier readback mismatch");

endmodule

bind counter_rng_multiply_xor crmx_chk u_chk (.*);
